// ----- hw/rtl/gdcr_pkg.sv -----
// shared types and constants for the column raycaster
package gdcr_pkg;

	localparam int unsigned NUM_REGS = 7;
	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;
	localparam logic [2:0] REG_PITCH   = 3'd6;

	localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
	localparam logic [7:0]  CH_SCALE  = 8'd85;
	localparam logic [7:0]  MASK_R    = 8'h30;
	localparam logic [7:0]  MASK_G    = 8'h0C;
	localparam logic [7:0]  MASK_B    = 8'h03;

	typedef struct packed {
		logic       req_type;
		logic [3:0] tile_row;
		logic [3:0] tile_col;
		logic [7:0] tile_value;
		logic [8:0] column;
	} req_t;

	typedef struct packed {
		logic [8:0]  out_column;
		logic        hit;
		logic        side;
		logic [7:0]  draw_start;
		logic [7:0]  draw_end;
		logic [23:0] color;
	} rsp_t;

	typedef struct packed {
		logic [19:0]        pos_x;
		logic [19:0]        pos_y;
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic signed [18:0] plane_x;
		logic signed [18:0] plane_y;
		logic signed [8:0]  view_pitch;
	} cfg_t;

	// divider handshake between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CAM, ST_RAY, ST_RDX, ST_RDY, ST_SIDE0, ST_SIDE1,
		ST_WALK, ST_READ, ST_TEST, ST_LINE, ST_SPAN, ST_OUT
	} state_t;

	function automatic logic [23:0] tile_color(input logic [7:0] t);
		logic [15:0] r, g, b;
		r = 16'((t & MASK_R) >> 4) * 16'(CH_SCALE);
		g = 16'((t & MASK_G) >> 2) * 16'(CH_SCALE);
		b = 16'(t & MASK_B) * 16'(CH_SCALE);
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

endpackage

// ----- hw/rtl/grid_dda_column_raycaster_unit.sv -----
// top level of the grid column raycaster
// Usage:
//  req_valid/req_ready carry one request: a tile write or a column cast.
//  A tile write is accepted while idle and gives no response.
//  A cast gives one response on rsp_valid/rsp_ready: column, hit, side,
//  the wall span rows and its color.
//  cfg_valid/cfg_ready write camera registers by index; write only while idle.
//  A cast occupies the block through the camera step, the ray step, the two
//  ray reciprocals, the x and then the y side distance, the map walk with
//  an address, a memory read and a test for each tile visited plus a last
//  address step when the ray leaves the map, the span step, the line height
//  division and the output step. A zero ray component or a zero distance
//  skips the wait for its division. The reciprocals and the line height
//  division share a 64 bit radix-2 divider. One request is in work at a time.
//  The finished response is held in an output register; a new request is
//  accepted while it waits, but its result waits for the previous one.
//  Reset clears the registers to their defaults and the map to empty at once.
//  When the receiver stalls, the response holds and no later cast completes.
module grid_dda_column_raycaster_unit #(
	parameter int unsigned MAP_WIDTH     = 16,
	parameter int unsigned MAP_HEIGHT    = 16,
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 240
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  gdcr_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gdcr_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [19:0]     cfg_data
);
	import gdcr_pkg::*;

	localparam int unsigned DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CAM_SHIFT = 22;
	localparam logic [40:0] CAM_MUL = 41'(((64'd1 << (17 + CAM_SHIFT))
		+ 64'(SCREEN_WIDTH) - 64'd2) / 64'(SCREEN_WIDTH - 1));
	localparam logic [63:0] LINE_NUM = 64'(SCREEN_HEIGHT) << 16;
	localparam logic signed [13:0] CENTER = 14'(SCREEN_HEIGHT / 2);
	localparam logic signed [13:0] ROW_MAX = 14'(SCREEN_HEIGHT - 1);

	cfg_t cfg_q;
	state_t st_q, st_d;
	req_t   req_q;
	rsp_t   rsp_q;
	logic   rsp_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic     div_go_q;
	logic     div_done;

	logic signed [18:0] cam_q;
	logic signed [20:0] rx_q, ry_q;
	logic [32:0] ddx_q, ddy_q;
	logic [40:0] dx_q, dy_q;
	logic signed [9:0] tx_q, ty_q;
	logic        stepped_q, side_q, hit_q;
	logic [7:0]  tile_q;
	logic [40:0] perp_q;
	logic [30:0] line_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x      <= 20'd327680;
			cfg_q.pos_y      <= 20'd327680;
			cfg_q.dir_x      <= -18'sd65536;
			cfg_q.dir_y      <= '0;
			cfg_q.plane_x    <= '0;
			cfg_q.plane_y    <= 19'sd43254;
			cfg_q.view_pitch <= 9'sd100;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POS_X:   cfg_q.pos_x      <= cfg_data;
				REG_POS_Y:   cfg_q.pos_y      <= cfg_data;
				REG_DIR_X:   cfg_q.dir_x      <= cfg_data[17:0];
				REG_DIR_Y:   cfg_q.dir_y      <= cfg_data[17:0];
				REG_PLANE_X: cfg_q.plane_x    <= cfg_data[18:0];
				REG_PLANE_Y: cfg_q.plane_y    <= cfg_data[18:0];
				REG_PITCH:   cfg_q.view_pitch <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// request decode
	logic req_fire, wr_fire;
	assign req_ready = (st_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign wr_fire   = req_fire && !req.req_type;

	assign mem_we    = wr_fire && (32'(req.tile_row) < MAP_HEIGHT)
		&& (32'(req.tile_col) < MAP_WIDTH);
	assign mem_waddr = AW'(32'(req.tile_row) * MAP_WIDTH + 32'(req.tile_col));
	assign mem_raddr = AW'(32'($unsigned(ty_q)) * MAP_WIDTH + 32'($unsigned(tx_q)));

	gdcr_tile_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .arst_n(arst_n), .we(mem_we), .waddr(mem_waddr),
		.wdata(req.tile_value), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	// shared divider operands by state
	always_comb begin
		dreq.start = div_go_q;
		dreq.num   = 64'd0;
		dreq.den   = 64'd1;
		case (st_q)
			ST_RDX: begin
				dreq.num = 64'd1 << 32;
				dreq.den = 64'(rx_q < 0 ? -rx_q : rx_q);
			end
			ST_RDY: begin
				dreq.num = 64'd1 << 32;
				dreq.den = 64'(ry_q < 0 ? -ry_q : ry_q);
			end
			ST_LINE: begin
				dreq.num = LINE_NUM;
				dreq.den = 64'(perp_q);
			end
			default: ;
		endcase
	end

	gdcr_divider u_div (.clk(clk), .arst_n(arst_n), .dreq(dreq), .drsp(drsp));

	// a done pulse in a start cycle belongs to an abandoned division
	assign div_done = drsp.done && !div_go_q;

	// walk helpers
	logic out_map;
	assign out_map = (tx_q < 0) || (32'(tx_q) >= MAP_WIDTH)
		|| (ty_q < 0) || (32'(ty_q) >= MAP_HEIGHT);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (req_fire && req.req_type) st_d = ST_CAM;
			ST_CAM:   st_d = ST_RAY;
			ST_RAY:   st_d = ST_RDX;
			ST_RDX:   if (div_done || rx_q == 0) st_d = ST_RDY;
			ST_RDY:   if (div_done || ry_q == 0) st_d = ST_SIDE0;
			ST_SIDE0: st_d = ST_SIDE1;
			ST_SIDE1: st_d = ST_WALK;
			ST_WALK:  st_d = out_map ? ST_SPAN : ST_READ;
			ST_READ:  st_d = ST_TEST;
			ST_TEST:  st_d = (mem_rdata != 8'd0) ? ST_SPAN : ST_WALK;
			ST_LINE:  if (div_done || perp_q == 0) st_d = ST_OUT;
			ST_SPAN:  st_d = ST_LINE;
			ST_OUT:   if (!rsp_valid_q || rsp_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// datapath
	logic [49:0] cam_prod;
	logic signed [37:0] prod_x, prod_y;
	logic signed [37:0] fx, fy;
	logic [15:0] fracx, fracy;
	logic [16:0] dfx, dfy;
	logic [49:0] sdx, sdy;
	assign cam_prod = 50'(req_q.column) * 50'(CAM_MUL);
	assign prod_x = 38'(cfg_q.plane_x) * 38'(cam_q);
	assign prod_y = 38'(cfg_q.plane_y) * 38'(cam_q);
	assign fx = prod_x >>> 16;
	assign fy = prod_y >>> 16;
	assign fracx = cfg_q.pos_x[15:0];
	assign fracy = cfg_q.pos_y[15:0];
	assign dfx = rx_q < 0 ? {1'b0, fracx} : 17'h10000 - {1'b0, fracx};
	assign dfy = ry_q < 0 ? {1'b0, fracy} : 17'h10000 - {1'b0, fracy};
	assign sdx = 50'(dfx) * 50'(ddx_q);
	assign sdy = 50'(dfy) * 50'(ddy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go_q <= 1'b0;
		else div_go_q <= (st_q == ST_RAY)
			|| (st_q == ST_RDX && (div_done || rx_q == 0))
			|| (st_q == ST_SPAN);
	end

	always_ff @(posedge clk) begin
		if (req_fire) req_q <= req;
		case (st_q)
			ST_CAM: cam_q <= 19'(cam_prod >> CAM_SHIFT) - 19'sd65536;
			ST_RAY: begin
				rx_q <= 21'(cfg_q.dir_x) + 21'(fx);
				ry_q <= 21'(cfg_q.dir_y) + 21'(fy);
			end
			ST_RDX: if (rx_q == 0) ddx_q <= 33'h100000000;
				else if (div_done) ddx_q <= drsp.quo[32:0];
			ST_RDY: if (ry_q == 0) ddy_q <= 33'h100000000;
				else if (div_done) ddy_q <= drsp.quo[32:0];
			ST_SIDE0: begin
				dx_q <= 41'(sdx >> 16);
				tx_q <= 10'(cfg_q.pos_x[19:16]);
				ty_q <= 10'(cfg_q.pos_y[19:16]);
				stepped_q <= 1'b0;
				side_q <= 1'b0;
				hit_q <= 1'b0;
			end
			ST_SIDE1: dy_q <= 41'(sdy >> 16);
			ST_TEST: begin
				if (mem_rdata != 8'd0) begin
					hit_q  <= 1'b1;
					tile_q <= mem_rdata;
				end else begin
					stepped_q <= 1'b1;
					if (dx_q < dy_q) begin
						dx_q <= dx_q + 41'(ddx_q);
						tx_q <= rx_q < 0 ? tx_q - 10'sd1 : tx_q + 10'sd1;
						side_q <= 1'b0;
					end else begin
						dy_q <= dy_q + 41'(ddy_q);
						ty_q <= ry_q < 0 ? ty_q - 10'sd1 : ty_q + 10'sd1;
						side_q <= 1'b1;
					end
				end
			end
			ST_SPAN: perp_q <= !stepped_q ? 41'd0
				: (side_q ? dy_q - 41'(ddy_q) : dx_q - 41'(ddx_q));
			ST_LINE: if (perp_q == 0) line_q <= 31'h40000000;
				else if (div_done) line_q <= (drsp.quo > 64'h40000000)
					? 31'h40000000 : drsp.quo[30:0];
			default: ;
		endcase
	end

	// span and color
	logic signed [31:0] half, center, s_raw, e_raw, s_cl, e_cl;
	logic [23:0] col_full;
	assign half   = 32'(line_q >> 1);
	assign center = 32'(CENTER) + 32'(cfg_q.view_pitch);
	assign s_raw  = center - half;
	assign e_raw  = center + half;
	assign s_cl   = s_raw < 0 ? 32'sd0 : (s_raw > 32'(ROW_MAX) ? 32'(ROW_MAX) : s_raw);
	assign e_cl   = e_raw < 0 ? 32'sd0 : (e_raw > 32'(ROW_MAX) ? 32'(ROW_MAX) : e_raw);
	assign col_full = tile_color(tile_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (st_q == ST_OUT && (!rsp_valid_q || rsp_ready)) rsp_valid_q <= 1'b1;
		else if (rsp_ready) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.out_column <= req_q.column;
			rsp_q.hit        <= hit_q;
			rsp_q.side       <= side_q;
			rsp_q.draw_start <= s_cl[7:0];
			rsp_q.draw_end   <= (e_cl < s_cl) ? s_cl[7:0] : e_cl[7:0];
			rsp_q.color      <= !hit_q ? 24'd0
				: (side_q ? ((col_full >> 1) & HALF_MASK) : col_full);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

// ----- hw/rtl/gdcr_divider.sv -----
// restoring divider, one quotient bit per cycle, 64 by 64 bits
module gdcr_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  gdcr_pkg::div_req_t dreq,
	output gdcr_pkg::div_rsp_t drsp
);
	import gdcr_pkg::*;

	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
				rem_q  <= '0;
				quo_q  <= dreq.num;
				den_q  <= dreq.den;
			end else if (busy_q) begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign drsp.done = done_q;
	assign drsp.quo  = quo_q;
endmodule

// ----- hw/rtl/gdcr_tile_mem.sv -----
// tile store: synchronous memory with one write and one read port, with valid bits for reset
module gdcr_tile_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import gdcr_pkg::*;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_q;
	logic             rv_q;

	// storage
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// valid bits clear the map at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (we) valid_q[waddr] <= 1'b1;
			rv_q <= valid_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : 8'd0;
endmodule

// ----- test/tb_grid_dda_column_raycaster_unit.sv -----
// testbench for the grid column raycaster: directed and random casts checked against a predictor
module tb_grid_dda_column_raycaster_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import gdcr_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int REG_WIDTH [7] = '{20, 20, 18, 18, 19, 19, 9};
	localparam logic [2:0] REG_NONE = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;

	// predictor state: camera registers and tile map
	logic [19:0] cam_regs [7];
	logic [7:0]  tile_map [256];
	rsp_t        span_queue [$];

	int errors;
	int cycles;
	bit calm;
	int stall_cycles;

	grid_dda_column_raycaster_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// expected span for one cast column
	function automatic rsp_t predict_span(input logic [8:0] col);
		longint cam, rx, ry, tx, ty, sx, sy, line, half, center, start, stop;
		longint unsigned ddx, ddy, dx, dy, perp, q, px, py;
		bit side, hit, stepped;
		logic [7:0] tile;
		logic [23:0] color;
		rsp_t r;
		side = 0;
		hit = 0;
		stepped = 0;
		tile = 0;
		color = 0;
		px = cam_regs[REG_POS_X];
		py = cam_regs[REG_POS_Y];
		cam = longint'((longint'(col) * 131072) / 319) - 65536;
		rx = longint'($signed(cam_regs[REG_DIR_X][17:0]))
			+ ((longint'($signed(cam_regs[REG_PLANE_X][18:0])) * cam) >>> 16);
		ry = longint'($signed(cam_regs[REG_DIR_Y][17:0]))
			+ ((longint'($signed(cam_regs[REG_PLANE_Y][18:0])) * cam) >>> 16);
		ddx = (rx == 0) ? 64'h1_0000_0000 : 64'h1_0000_0000 / longint'(rx < 0 ? -rx : rx);
		ddy = (ry == 0) ? 64'h1_0000_0000 : 64'h1_0000_0000 / longint'(ry < 0 ? -ry : ry);
		tx = px >> 16;
		ty = py >> 16;
		if (rx < 0) begin
			sx = -1;
			dx = ((px & 16'hFFFF) * ddx) >> 16;
		end else begin
			sx = 1;
			dx = ((65536 - (px & 16'hFFFF)) * ddx) >> 16;
		end
		if (ry < 0) begin
			sy = -1;
			dy = ((py & 16'hFFFF) * ddy) >> 16;
		end else begin
			sy = 1;
			dy = ((65536 - (py & 16'hFFFF)) * ddy) >> 16;
		end
		// grid walk
		forever begin
			if (tx < 0 || tx >= 16 || ty < 0 || ty >= 16) break;
			tile = tile_map[ty * 16 + tx];
			if (tile != 0) begin
				hit = 1;
				break;
			end
			stepped = 1;
			if (dx < dy) begin
				dx += ddx;
				tx += sx;
				side = 0;
			end else begin
				dy += ddy;
				ty += sy;
				side = 1;
			end
		end
		if (!stepped) perp = 0;
		else perp = side ? dy - ddy : dx - ddx;
		if (perp == 0) begin
			line = 64'd1073741824;
		end else begin
			q = (64'd240 << 16) / perp;
			line = (q > 64'd1073741824) ? 64'd1073741824 : longint'(q);
		end
		half = line / 2;
		center = 120 + longint'($signed(cam_regs[REG_PITCH][8:0]));
		start = center - half;
		stop = center + half;
		start = start < 0 ? 0 : (start > 239 ? 239 : start);
		stop = stop < 0 ? 0 : (stop > 239 ? 239 : stop);
		if (stop < start) stop = start;
		if (hit) begin
			color = {8'(((tile >> 4) & 3) * 85), 8'(((tile >> 2) & 3) * 85), 8'((tile & 3) * 85)};
			if (side) color = (color >> 1) & HALF_MASK;
		end
		r.out_column = col;
		r.hit = hit;
		r.side = side;
		r.draw_start = 8'(start);
		r.draw_end = 8'(stop);
		r.color = color;
		return r;
	endfunction

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (span_queue.size() == 0) begin
				report_mismatch("unexpected response", rsp.out_column, 0);
			end else begin
				want = span_queue.pop_front();
				if (rsp.out_column !== want.out_column)
					report_mismatch("out_column", rsp.out_column, want.out_column);
				if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
				if (rsp.side !== want.side) report_mismatch("side", rsp.side, want.side);
				if (rsp.draw_start !== want.draw_start)
					report_mismatch("draw_start", rsp.draw_start, want.draw_start);
				if (rsp.draw_end !== want.draw_end)
					report_mismatch("draw_end", rsp.draw_end, want.draw_end);
				if (rsp.color !== want.color) report_mismatch("color", rsp.color, want.color);
			end
		end
	end

	// receiver readiness with random idling and long hold-offs
	always @(negedge clk) begin
		if (stall_cycles > 0) begin
			rsp_ready <= 1'b0;
			stall_cycles <= stall_cycles - 1;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 34);
		end
	end

	// send one request and update the predictor on acceptance
	task automatic send_request(input req_t r);
		int gap;
		gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(4, 1) : 0;
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (r.req_type) span_queue.push_back(predict_span(r.column));
		else tile_map[{r.tile_row, r.tile_col}] = r.tile_value;
	endtask

	task automatic put_tile(input int row, input int col, input logic [7:0] val);
		req_t r;
		r = '0;
		r.tile_row = 4'(row);
		r.tile_col = 4'(col);
		r.tile_value = val;
		send_request(r);
	endtask

	task automatic cast_column(input logic [8:0] col);
		req_t r;
		r = '0;
		r.req_type = 1'b1;
		r.column = col;
		send_request(r);
	endtask

	task automatic drain_spans();
		@(negedge clk);
		req_valid <= 1'b0;
		while (span_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// register write, only while idle
	task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
		drain_spans();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS) cam_regs[idx] = data & ((20'd1 << REG_WIDTH[idx]) - 1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic clear_map();
		for (int i = 0; i < 256; i++)
			if (tile_map[i] != 0) put_tile(i / 16, i % 16, 8'h00);
	endtask

	task automatic test_directed();
		// empty map: ray leaves the map
		cast_column(9'd0);
		cast_column(9'd319);
		// walls at the map corners and full-range tile codes
		put_tile(0, 0, 8'hFF);
		put_tile(15, 15, 8'h3F);
		put_tile(0, 15, 8'h40);
		put_tile(15, 0, 8'h15);
		put_tile(5, 0, 8'h2A);
		put_tile(0, 5, 8'h01);
		cast_column(9'd0);
		cast_column(9'd160);
		cast_column(9'd319);
		// column beyond the screen
		cast_column(9'd511);
		cast_column(9'd320);
		// wall at the camera tile
		put_tile(5, 5, 8'h33);
		cast_column(9'd100);
		put_tile(5, 5, 8'h00);
		cast_column(9'd100);
		drain_spans();
	endtask

	task automatic test_config_extremes();
		// zero ray component in y
		write_reg(REG_PLANE_Y, 20'd0);
		cast_column(9'd50);
		// extreme registers
		write_reg(REG_POS_X, 20'd0);
		write_reg(REG_POS_Y, 20'hFFFFF);
		write_reg(REG_DIR_X, 20'h10000);
		write_reg(REG_DIR_Y, 20'h30000);
		write_reg(REG_PLANE_X, 20'h60000);
		write_reg(REG_PLANE_Y, 20'h20000);
		write_reg(REG_PITCH, 20'h10);
		cast_column(9'd0);
		cast_column(9'd319);
		write_reg(REG_PITCH, 20'h1F0 & 20'h1FF);
		write_reg(REG_PITCH, 20'h110);
		cast_column(9'd200);
		write_reg(REG_PITCH, 20'd240);
		cast_column(9'd10);
		// both ray components zero: direction and plane are zero for every column
		write_reg(REG_DIR_X, 20'd0);
		write_reg(REG_DIR_Y, 20'd0);
		write_reg(REG_PLANE_X, 20'd0);
		write_reg(REG_PLANE_Y, 20'd0);
		put_tile(15, 0, 8'h00);
		cast_column(9'd7);
		// index past the register list is ignored
		write_reg(REG_NONE, 20'hABCDE);
		cast_column(9'd7);
		drain_spans();
	endtask

	task automatic test_random();
		int density;
		for (int phase = 0; phase < 10; phase++) begin
			calm = (phase == 3);
			for (int i = 0; i < 7; i++) write_reg(3'(i), 20'($urandom));
			if (phase % 3 == 0) clear_map();
			density = $urandom_range(60);
			for (int n = 0; n < 110; n++) begin
				if ($urandom_range(99) < 40) begin
					if ($urandom_range(99) < density)
						put_tile($urandom_range(15), $urandom_range(15), 8'($urandom));
					else
						put_tile($urandom_range(15), $urandom_range(15), 8'h00);
				end else if ($urandom_range(99) < 95) begin
					cast_column(9'($urandom_range(319)));
				end else begin
					cast_column(9'($urandom));
				end
			end
		end
		calm = 0;
		drain_spans();
	endtask

	task automatic test_backpressure();
		// receiver holds off while casts keep coming
		put_tile(2, 2, 8'h2D);
		stall_cycles = 3000;
		for (int n = 0; n < 12; n++) cast_column(9'($urandom_range(319)));
		drain_spans();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		calm = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cam_regs[0] = 20'd327680;
		cam_regs[1] = 20'd327680;
		cam_regs[2] = 20'h30000;
		cam_regs[3] = 20'd0;
		cam_regs[4] = 20'd0;
		cam_regs[5] = 20'd43254;
		cam_regs[6] = 20'd100;
		for (int i = 0; i < 256; i++) tile_map[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random();

		drain_spans();
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/gdcr_pkg.sv
hw/rtl/gdcr_divider.sv
hw/rtl/gdcr_tile_mem.sv
hw/rtl/grid_dda_column_raycaster_unit.sv
test/tb_grid_dda_column_raycaster_unit.sv
